// ----- rtl/ipdm_pkg.sv -----
// Shared types and constants for the IR pulse-distance modulator.
package ipdm_pkg;

   localparam int CFG_DATA_WIDTH  = 24;
   localparam int CFG_INDEX_WIDTH = 3;

   localparam logic FUNC_TICK = 1'b0;
   localparam logic FUNC_LOAD = 1'b1;

   typedef struct packed {
      logic       is_load;
      logic [7:0] byte_value;
      logic       last_byte;
   } req_entry_type;

   typedef struct packed {
      logic [15:0] preamble_bursts;
      logic [15:0] preamble_space;
      logic [15:0] one_space;
      logic [15:0] zero_space;
      logic [15:0] gap_bursts;
      logic [23:0] wait_ticks;
      logic [2:0]  options;
   } cfg_type;

   typedef struct packed {
      logic pin_level;
      logic byte_wanted;
      logic busy_res;
      logic overrun;
      logic underrun;
   } rsp_type;

endpackage

// ----- rtl/ipdm_csr.sv -----
// Configuration register file for the IR pulse-distance modulator.
module ipdm_csr import ipdm_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wr_en,
   input  logic [CFG_INDEX_WIDTH-1:0] csr_index,
   input  logic [CFG_DATA_WIDTH-1:0]  csr_wdata,
   output cfg_type                    cfg
);

   localparam logic [CFG_INDEX_WIDTH-1:0] REG_PREAMBLE_BURSTS = 3'd0;
   localparam logic [CFG_INDEX_WIDTH-1:0] REG_PREAMBLE_SPACE  = 3'd1;
   localparam logic [CFG_INDEX_WIDTH-1:0] REG_ONE_SPACE       = 3'd2;
   localparam logic [CFG_INDEX_WIDTH-1:0] REG_ZERO_SPACE      = 3'd3;
   localparam logic [CFG_INDEX_WIDTH-1:0] REG_GAP_BURSTS      = 3'd4;
   localparam logic [CFG_INDEX_WIDTH-1:0] REG_WAIT_TICKS      = 3'd5;
   localparam logic [CFG_INDEX_WIDTH-1:0] REG_OPTIONS         = 3'd6;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            REG_PREAMBLE_BURSTS: cfg_in.preamble_bursts = csr_wdata[15:0];
            REG_PREAMBLE_SPACE:  cfg_in.preamble_space  = csr_wdata[15:0];
            REG_ONE_SPACE:       cfg_in.one_space       = csr_wdata[15:0];
            REG_ZERO_SPACE:      cfg_in.zero_space      = csr_wdata[15:0];
            REG_GAP_BURSTS:      cfg_in.gap_bursts      = csr_wdata[15:0];
            REG_WAIT_TICKS:      cfg_in.wait_ticks      = csr_wdata[23:0];
            REG_OPTIONS:         cfg_in.options         = csr_wdata[2:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- rtl/ipdm_front.sv -----
// Request front end: decodes requests and queues them for the sequencer.
module ipdm_front import ipdm_pkg::*; #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic          req_func,
   input  logic [7:0]    req_byte_value,
   input  logic          req_last_byte,
   output logic          q_valid,
   output req_entry_type q_entry,
   input  logic          q_pop
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

   req_entry_type    slot_ff [QUEUE_DEPTH];
   req_entry_type    slot_in;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push;

   assign req_ready = (count_ff != FULL_CNT);
   assign push      = req_valid & req_ready;
   assign q_valid   = (count_ff != '0);
   assign q_entry   = slot_ff[rd_ptr_ff];

   always_comb begin
      slot_in.is_load    = (req_func == FUNC_LOAD);
      slot_in.byte_value = req_byte_value;
      slot_in.last_byte  = req_last_byte;
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      unique case ({push, q_pop})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= slot_in;
      end
   end

endmodule

// ----- rtl/ipdm_back.sv -----
// Frame sequencer: holding register, phase sequencing and result register.
module ipdm_back import ipdm_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  cfg_type       cfg,
   input  logic          cfg_write,
   input  logic          q_valid,
   input  req_entry_type q_entry,
   output logic          q_pop,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output rsp_type       rsp
);

   localparam logic [2:0] PH_IDLE      = 3'd0;
   localparam logic [2:0] PH_PRE_MARK  = 3'd1;
   localparam logic [2:0] PH_PRE_SPACE = 3'd2;
   localparam logic [2:0] PH_PRE_GAP   = 3'd3;
   localparam logic [2:0] PH_BIT_SPACE = 3'd4;
   localparam logic [2:0] PH_BIT_GAP   = 3'd5;
   localparam logic [2:0] PH_WAIT      = 3'd6;
   localparam logic [2:0] EP_END_BYTE  = 3'd7;
   localparam logic [2:0] LAST_BIT     = 3'd7;

   typedef struct packed {
      logic       found;
      logic [3:0] slot;
   } slot_hit_type;

   function automatic logic [7:0] shape_byte(input logic [7:0] b, input logic [2:0] opt);
      logic [7:0] s;
      logic [7:0] r;
      int         i;
      s = opt[0] ? {b[3:0], b[7:4]} : b;
      for (i = 0; i < 8; i++) begin
         r[i] = s[7-i];
      end
      return opt[1] ? r : s;
   endfunction

   // slot 2j: space of bit j, slot 2j+1: gap after bit j
   function automatic logic [15:0] slot_nz(input logic [7:0] b, input logic l,
                                           input logic skip_en, input logic one_nz,
                                           input logic zero_nz, input logic gap_nz);
      logic [15:0] nz;
      logic        skip;
      int          j;
      for (j = 0; j < 8; j++) begin
         skip        = skip_en & l & (j > 3) & ~b[j];
         nz[2*j]     = ~skip & (b[j] ? one_nz : zero_nz);
         nz[2*j + 1] = ~skip & gap_nz;
      end
      return nz;
   endfunction

   function automatic slot_hit_type first_slot(input logic [15:0] nz, input logic [3:0] from);
      slot_hit_type hit;
      int           k;
      hit = '0;
      for (k = 15; k >= 0; k--) begin
         if (nz[k] && (4'(k) >= from)) begin
            hit.found = 1'b1;
            hit.slot  = 4'(k);
         end
      end
      return hit;
   endfunction

   logic [2:0]  phase_ff, phase_in;
   logic [23:0] count_ff, count_in;
   logic        half_ff, half_in;
   logic [2:0]  bit_ff, bit_in;
   logic [7:0]  shift_ff, shift_in;
   logic        slast_ff, slast_in;
   logic [7:0]  hold_ff, hold_in;
   logic        hvalid_ff, hvalid_in;
   logic        hlast_ff, hlast_in;
   logic        resettle_ff, resettle_in;
   logic        settle_end_ff, settle_end_in;
   logic        urun_pend_ff, urun_pend_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;

   logic        pm_nz, ps_nz, one_nz, zero_nz, gap_nz, wait_nz;
   logic [7:0]  held_shaped;
   logic        cur_bit, cur_skip;
   logic [23:0] cur_len, cnt_inc;
   logic        cnt_done;
   logic        out_free, settle_cycle, item_go;

   logic [2:0]  ep, ep_bit;
   logic [7:0]  ep_byte;
   logic        ep_last, ep_hold;

   logic [15:0]  nz_a, nz_b;
   logic [3:0]   from;
   slot_hit_type hit_a, hit_b;
   logic         search, end_byte, to_wait;
   logic [2:0]   res_phase, res_bit;
   logic [7:0]   res_shift;
   logic         res_last, res_take, res_under;
   logic         finish, moved;

   assign pm_nz   = |cfg.preamble_bursts;
   assign ps_nz   = |cfg.preamble_space;
   assign one_nz  = |cfg.one_space;
   assign zero_nz = |cfg.zero_space;
   assign gap_nz  = |cfg.gap_bursts;
   assign wait_nz = |cfg.wait_ticks;

   assign held_shaped = shape_byte(hold_ff, cfg.options);
   assign cur_bit     = shift_ff[bit_ff];
   assign cur_skip    = cfg.options[2] & slast_ff & (bit_ff > 3'd3) & ~cur_bit;
   assign cnt_inc     = count_ff + 24'd1;
   assign cnt_done    = (cnt_inc >= cur_len);

   assign out_free     = ~rsp_valid_ff | rsp_ready;
   // after a register write a tick first re-settles the current phase
   assign settle_cycle = resettle_ff & q_valid & ~q_entry.is_load;
   assign item_go      = q_valid & out_free & ~settle_cycle;
   assign q_pop        = item_go;

   always_comb begin
      unique case (phase_ff)
         PH_PRE_MARK:  cur_len = 24'(cfg.preamble_bursts);
         PH_PRE_SPACE: cur_len = 24'(cfg.preamble_space);
         PH_PRE_GAP:   cur_len = 24'(cfg.gap_bursts);
         PH_BIT_SPACE: cur_len = cur_skip ? '0 : 24'(cur_bit ? cfg.one_space : cfg.zero_space);
         PH_BIT_GAP:   cur_len = cur_skip ? '0 : 24'(cfg.gap_bursts);
         PH_WAIT:      cur_len = cfg.wait_ticks;
         default:      cur_len = '0;
      endcase
   end

   // entry point of the phase search
   always_comb begin
      ep      = PH_IDLE;
      ep_bit  = bit_ff;
      ep_byte = shift_ff;
      ep_last = slast_ff;
      ep_hold = hvalid_ff;
      if (settle_cycle) begin
         ep = phase_ff;
      end else if (phase_ff == PH_IDLE) begin
         ep      = PH_PRE_MARK;
         ep_bit  = '0;
         ep_byte = held_shaped;
         ep_last = hlast_ff;
         ep_hold = 1'b0;
      end else begin
         unique case (phase_ff)
            PH_PRE_MARK:  ep = PH_PRE_SPACE;
            PH_PRE_SPACE: ep = PH_PRE_GAP;
            PH_PRE_GAP: begin
               ep     = PH_BIT_SPACE;
               ep_bit = '0;
            end
            PH_BIT_SPACE: ep = PH_BIT_GAP;
            PH_BIT_GAP: begin
               if (bit_ff == LAST_BIT) begin
                  ep = EP_END_BYTE;
               end else begin
                  ep     = PH_BIT_SPACE;
                  ep_bit = bit_ff + 3'd1;
               end
            end
            default: ep = PH_IDLE;
         endcase
      end
   end

   // skip every zero-length phase from the entry point
   always_comb begin
      nz_a = slot_nz(ep_byte, ep_last, cfg.options[2], one_nz, zero_nz, gap_nz);
      nz_b = slot_nz(held_shaped, hlast_ff, cfg.options[2], one_nz, zero_nz, gap_nz);
      search    = 1'b0;
      end_byte  = 1'b0;
      to_wait   = 1'b0;
      from      = '0;
      res_phase = PH_IDLE;
      res_bit   = ep_bit;
      res_shift = ep_byte;
      res_last  = ep_last;
      res_take  = 1'b0;
      res_under = 1'b0;
      unique case (ep)
         PH_IDLE: res_phase = PH_IDLE;
         PH_PRE_MARK: begin
            if (pm_nz) begin
               res_phase = PH_PRE_MARK;
            end else if (ps_nz) begin
               res_phase = PH_PRE_SPACE;
            end else if (gap_nz) begin
               res_phase = PH_PRE_GAP;
            end else begin
               search = 1'b1;
            end
         end
         PH_PRE_SPACE: begin
            if (ps_nz) begin
               res_phase = PH_PRE_SPACE;
            end else if (gap_nz) begin
               res_phase = PH_PRE_GAP;
            end else begin
               search = 1'b1;
            end
         end
         PH_PRE_GAP: begin
            if (gap_nz) begin
               res_phase = PH_PRE_GAP;
            end else begin
               search = 1'b1;
            end
         end
         PH_BIT_SPACE: begin
            search = 1'b1;
            from   = {ep_bit, 1'b0};
         end
         PH_BIT_GAP: begin
            search = 1'b1;
            from   = {ep_bit, 1'b1};
         end
         PH_WAIT: to_wait = 1'b1;
         default: end_byte = 1'b1;
      endcase
      hit_a = first_slot(nz_a, from);
      hit_b = first_slot(nz_b, '0);
      if (search && hit_a.found) begin
         res_phase = hit_a.slot[0] ? PH_BIT_GAP : PH_BIT_SPACE;
         res_bit   = hit_a.slot[3:1];
      end else if (search || end_byte) begin
         res_bit = LAST_BIT;
         if (ep_last) begin
            to_wait = 1'b1;
         end else if (ep_hold) begin
            res_take  = 1'b1;
            res_shift = held_shaped;
            res_last  = hlast_ff;
            if (hit_b.found) begin
               res_phase = hit_b.slot[0] ? PH_BIT_GAP : PH_BIT_SPACE;
               res_bit   = hit_b.slot[3:1];
            end else if (hlast_ff) begin
               to_wait = 1'b1;
            end else begin
               res_under = 1'b1;
               to_wait   = 1'b1;
            end
         end else begin
            res_under = 1'b1;
            to_wait   = 1'b1;
         end
      end
      if (to_wait) begin
         res_phase = wait_nz ? PH_WAIT : PH_IDLE;
      end
   end

   always_comb begin
      phase_in      = phase_ff;
      count_in      = count_ff;
      half_in       = half_ff;
      bit_in        = bit_ff;
      shift_in      = shift_ff;
      slast_in      = slast_ff;
      hold_in       = hold_ff;
      hvalid_in     = hvalid_ff;
      hlast_in      = hlast_ff;
      urun_pend_in  = urun_pend_ff;
      settle_end_in = settle_end_ff;
      resettle_in   = cfg_write | (resettle_ff & ~settle_cycle);
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      rsp_in        = rsp_ff;
      finish        = 1'b0;
      moved         = res_take | (res_phase != phase_ff) | (res_bit != bit_ff);
      if (settle_cycle) begin
         phase_in     = res_phase;
         bit_in       = res_bit;
         shift_in     = res_shift;
         slast_in     = res_last;
         urun_pend_in = urun_pend_ff | res_under;
         // a frame closed here does not restart on the same tick
         settle_end_in = (phase_ff != PH_IDLE) & (res_phase == PH_IDLE);
         if (res_take) begin
            hvalid_in = 1'b0;
            hlast_in  = 1'b0;
         end
         if (moved) begin
            count_in = '0;
            half_in  = 1'b0;
         end
      end else if (item_go) begin
         rsp_valid_in     = 1'b1;
         rsp_in.pin_level = 1'b0;
         rsp_in.overrun   = 1'b0;
         rsp_in.underrun  = 1'b0;
         if (q_entry.is_load) begin
            if (hvalid_ff) begin
               rsp_in.overrun = 1'b1;
            end else begin
               hold_in   = q_entry.byte_value;
               hlast_in  = q_entry.last_byte;
               hvalid_in = 1'b1;
            end
         end else begin
            urun_pend_in    = 1'b0;
            settle_end_in   = 1'b0;
            rsp_in.underrun = urun_pend_ff;
            if (phase_ff == PH_IDLE) begin
               if (hvalid_ff & ~settle_end_ff) begin
                  hvalid_in       = 1'b0;
                  hlast_in        = 1'b0;
                  shift_in        = res_shift;
                  slast_in        = res_last;
                  bit_in          = res_bit;
                  rsp_in.underrun = urun_pend_ff | res_under;
                  count_in        = '0;
                  half_in         = 1'b0;
                  if (res_phase == PH_WAIT) begin
                     if (cfg.wait_ticks <= 24'd1) begin
                        phase_in = PH_IDLE;
                     end else begin
                        phase_in = PH_WAIT;
                        count_in = 24'd1;
                     end
                  end else if (res_phase == PH_IDLE) begin
                     phase_in = PH_IDLE;
                  end else begin
                     phase_in         = res_phase;
                     half_in          = 1'b1;
                     rsp_in.pin_level = (res_phase == PH_PRE_MARK) |
                                        (res_phase == PH_PRE_GAP) |
                                        (res_phase == PH_BIT_GAP);
                  end
               end
            end else if (phase_ff == PH_WAIT) begin
               if (cnt_done) begin
                  finish = 1'b1;
               end else begin
                  count_in = cnt_inc;
               end
            end else begin
               rsp_in.pin_level = ~half_ff & ((phase_ff == PH_PRE_MARK) |
                                              (phase_ff == PH_PRE_GAP) |
                                              (phase_ff == PH_BIT_GAP));
               if (half_ff) begin
                  half_in = 1'b0;
                  if (cnt_done) begin
                     finish = 1'b1;
                  end else begin
                     count_in = cnt_inc;
                  end
               end else begin
                  half_in = 1'b1;
               end
            end
            if (finish) begin
               phase_in        = res_phase;
               bit_in          = res_bit;
               shift_in        = res_shift;
               slast_in        = res_last;
               count_in        = '0;
               half_in         = 1'b0;
               rsp_in.underrun = urun_pend_ff | res_under;
               if (res_take) begin
                  hvalid_in = 1'b0;
                  hlast_in  = 1'b0;
               end
            end
         end
         rsp_in.byte_wanted = ~hvalid_in;
         rsp_in.busy_res    = (phase_in != PH_IDLE);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         count_ff      <= '0;
         half_ff       <= 1'b0;
         bit_ff        <= '0;
         slast_ff      <= 1'b0;
         hvalid_ff     <= 1'b0;
         hlast_ff      <= 1'b0;
         resettle_ff   <= 1'b0;
         settle_end_ff <= 1'b0;
         urun_pend_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         count_ff      <= count_in;
         half_ff       <= half_in;
         bit_ff        <= bit_in;
         slast_ff      <= slast_in;
         hvalid_ff     <= hvalid_in;
         hlast_ff      <= hlast_in;
         resettle_ff   <= resettle_in;
         settle_end_ff <= settle_end_in;
         urun_pend_ff  <= urun_pend_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      hold_ff  <= hold_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

// ----- rtl/ir_pulse_distance_modulator_top.sv -----
// Top level of the IR pulse-distance modulator.
//
//   channel  dir  handshake            contents
//   req_     in   valid/ready          func, byte_value, last_byte
//   rsp_     out  valid/ready          pin_level, byte_wanted, busy_res, overrun, underrun
//   csr_     in   write enable only    index, write data
//
// One request per clock while the response register is free and no re-settle is due; each
// request gives one response, registered in the cycle after the sequencer takes it from the request queue.
// A tick that follows a register write waits while the sequencer first re-settles the phase.
// Reset is synchronous and leaves the sequencer idle with an empty holding register.
// rsp_ready low holds the response register; the request queue accepts until it is full.
module ir_pulse_distance_modulator_top import ipdm_pkg::*; #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_func,
   input  logic [7:0]                 req_byte_value,
   input  logic                       req_last_byte,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic                       rsp_pin_level,
   output logic                       rsp_byte_wanted,
   output logic                       rsp_busy_res,
   output logic                       rsp_overrun,
   output logic                       rsp_underrun,
   input  logic                       csr_wr_en,
   input  logic [CFG_INDEX_WIDTH-1:0] csr_index,
   input  logic [CFG_DATA_WIDTH-1:0]  csr_wdata
);

   cfg_type       cfg;
   logic          q_valid;
   logic          q_pop;
   req_entry_type q_entry;
   rsp_type       rsp;

   ipdm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ipdm_front #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_func       (req_func),
      .req_byte_value (req_byte_value),
      .req_last_byte  (req_last_byte),
      .q_valid        (q_valid),
      .q_entry        (q_entry),
      .q_pop          (q_pop)
   );

   ipdm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cfg_write (csr_wr_en),
      .q_valid   (q_valid),
      .q_entry   (q_entry),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp)
   );

   assign rsp_pin_level   = rsp.pin_level;
   assign rsp_byte_wanted = rsp.byte_wanted;
   assign rsp_busy_res    = rsp.busy_res;
   assign rsp_overrun     = rsp.overrun;
   assign rsp_underrun    = rsp.underrun;

endmodule
